// ----- hw/rtl/ritoa_pkg.sv -----
// Package for the radix integer to ASCII converter.
// Holds the sizes, the ASCII offsets, the divider handshake types and the digit encoder.
// Used by every module of the block but ritoa_ram; depends on nothing else.
`timescale 1ns / 1ps

package ritoa_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int MAX_DIGITS  = 64;
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
  localparam int DIGIT_W     = 4;
  localparam int RADIX_W     = 5;
  localparam int CHAR_W      = 8;

  // The divider retires this many quotient bits per clock.
  localparam int DIV_STEPS   = 8;
  localparam int DIV_CYCLES  = (VALUE_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_W       = DIV_CYCLES * DIV_STEPS;
  localparam int DIV_CNT_W   = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

  localparam logic [CHAR_W-1:0] ASCII_ZERO   = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ALPHA_UP_OFS = CHAR_W'(55);
  localparam logic [CHAR_W-1:0] ALPHA_LO_OFS = CHAR_W'(87);
  localparam logic [DIGIT_W-1:0] DEC_MAX     = DIGIT_W'(9);

  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [RADIX_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [DIGIT_W-1:0]     remainder;
  } div_rsp_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] ofs;
    if (d > DEC_MAX) begin
      ofs = upper ? ALPHA_UP_OFS : ALPHA_LO_OFS;
    end else begin
      ofs = ASCII_ZERO;
    end
    return CHAR_W'(d) + ofs;
  endfunction

endpackage

// ----- hw/rtl/ritoa_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// Width and depth are parameters; no dependencies.
`timescale 1ns / 1ps

module ritoa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/ritoa_div.sv -----
// Iterative divider of the value by the radix, a few quotient bits per clock.
// Depends on ritoa_pkg for sizes and the request and response types.
`timescale 1ns / 1ps

module ritoa_div (
  input  logic               clk,
  input  logic               rst,
  input  ritoa_pkg::div_req_t req,
  output ritoa_pkg::div_rsp_t rsp
);
  import ritoa_pkg::*;

  logic                 running;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     work;
  logic [DIGIT_W-1:0]   rem;
  logic [RADIX_W-1:0]   divisor;
  logic [DIV_W-1:0]     work_next;
  logic [DIGIT_W-1:0]   rem_next;

  // Restoring division: the remainder stays below the divisor, so each
  // step is a five-bit compare and subtract. Quotient bits shift in at the
  // bottom as dividend bits leave at the top.
  always_comb begin
    logic [RADIX_W-1:0] r;
    logic [RADIX_W-1:0] t;
    logic               qb;
    work_next = work;
    r         = RADIX_W'(rem);
    for (int i = 0; i < DIV_STEPS; i++) begin
      t  = {r[RADIX_W-2:0], work_next[DIV_W-1]};
      qb = (t >= divisor);
      r  = qb ? (t - divisor) : t;
      work_next = {work_next[DIV_W-2:0], qb};
    end
    rem_next = r[DIGIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= '0;
        work    <= DIV_W'(req.dividend);
        rem     <= '0;
        divisor <= req.divisor;
      end else if (running) begin
        work <= work_next;
        rem  <= rem_next;
        cnt  <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = work[VALUE_WIDTH-1:0];
  assign rsp.remainder = rem;

endmodule

// ----- hw/rtl/radix_integer_to_ascii.sv -----
// Radix integer to ASCII: one item in, its digits out most significant first.
// Each digit is one division in the divider, which shifts the quotient in a byte at a time,
// so a valid item with D digits takes D divisions before its characters are read out;
// the next item is taken once the last character read is issued.
// A bad radix gives its single error result in the cycle after acceptance.
// Synchronous reset returns the sequencer to idle; the digit store is not cleared.
`timescale 1ns / 1ps

module radix_integer_to_ascii (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [63:0]                      value,
  input  logic [ritoa_pkg::RADIX_W-1:0]    radix,
  input  logic                             uppercase,
  output logic                             strobe,
  output logic [ritoa_pkg::CHAR_W-1:0]     character,
  output logic                             last,
  output logic                             error
);
  import ritoa_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_READ} state_t;

  state_t              state;
  logic [CNT_W-1:0]    digit_count;
  logic [ADDR_W-1:0]   rd_ptr;
  logic                upper_q;
  logic [RADIX_W-1:0]  radix_q;
  logic                rd_pend;
  logic                rd_last;
  logic                err_pend;

  logic                accept;
  logic                radix_bad;
  logic                more;
  logic [CNT_W-1:0]    count_next;
  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic                ram_we;
  logic                ram_re;
  logic [DIGIT_W-1:0]  ram_rdata;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign radix_bad  = (radix < RADIX_MIN) || (radix > RADIX_MAX);
  assign count_next = digit_count + 1'b1;
  // A zero value still takes one division, which leaves the single digit 0.
  assign more       = (div_rsp.quotient != '0) && (count_next < CNT_W'(MAX_DIGITS));
  assign ram_we     = (state == S_DIV) && div_rsp.done;
  assign ram_re     = (state == S_READ);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = div_rsp.quotient;
    div_req.divisor  = radix_q;
    if (state == S_IDLE) begin
      div_req.start    = accept && !radix_bad;
      div_req.dividend = value[VALUE_WIDTH-1:0];
      div_req.divisor  = radix;
    end else if (state == S_DIV) begin
      div_req.start = div_rsp.done && more;
    end
  end

  ritoa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ritoa_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (digit_count[ADDR_W-1:0]),
    .wdata (div_rsp.remainder),
    .re    (ram_re),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      digit_count <= '0;
      rd_pend     <= 1'b0;
      rd_last     <= 1'b0;
      err_pend    <= 1'b0;
    end else begin
      rd_pend  <= 1'b0;
      rd_last  <= 1'b0;
      err_pend <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (radix_bad) begin
              err_pend <= 1'b1;
            end else begin
              state       <= S_DIV;
              digit_count <= '0;
              upper_q     <= uppercase;
              radix_q     <= radix;
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            digit_count <= count_next;
            if (!more) begin
              state  <= S_READ;
              rd_ptr <= digit_count[ADDR_W-1:0];
            end
          end
        end
        S_READ: begin
          // Digits were stored least significant first; read them back downward.
          rd_pend <= 1'b1;
          rd_last <= (rd_ptr == '0);
          if (rd_ptr == '0) begin
            state <= S_IDLE;
          end else begin
            rd_ptr <= rd_ptr - 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign strobe    = rd_pend || err_pend;
  assign error     = err_pend;
  assign last      = rd_last || err_pend;
  assign character = rd_pend ? digit_char(ram_rdata, upper_q) : '0;

endmodule

// ----- hw/rtl/ritoa_chk.sv -----
// Port-level checker for the radix integer to ASCII converter, bound to the top level.
// Depends on ritoa_pkg for the radix limits and field widths.
`timescale 1ns / 1ps

module ritoa_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic [ritoa_pkg::RADIX_W-1:0] radix,
  input logic                         strobe,
  input logic [ritoa_pkg::CHAR_W-1:0] character,
  input logic                         last,
  input logic                         error
);
  import ritoa_pkg::*;

  // A rejected radix answers with an error item in the next cycle.
  a_bad_radix: assert property (@(posedge clk) disable iff (rst)
    start && !busy && ((radix < RADIX_MIN) || (radix > RADIX_MAX)) |=> strobe && error)
    else $error("bad radix did not give an error item");

  // A good radix starts a conversion, and no item appears in the next cycle.
  a_good_radix: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (radix >= RADIX_MIN) && (radix <= RADIX_MAX) |=> busy && !strobe)
    else $error("conversion did not start");

  a_error_form: assert property (@(posedge clk) disable iff (rst)
    strobe && error |-> last && (character == '0))
    else $error("error item is malformed");

  a_digit_set: assert property (@(posedge clk) disable iff (rst)
    strobe && !error |-> ((character >= 8'd48) && (character <= 8'd57)) ||
                         ((character >= 8'd65) && (character <= 8'd70)) ||
                         ((character >= 8'd97) && (character <= 8'd102)))
    else $error("character is not a digit");

  a_quiet: assert property (@(posedge clk) disable iff (rst)
    !strobe |-> !last && !error)
    else $error("flags raised without an item");

endmodule

bind radix_integer_to_ascii ritoa_chk u_ritoa_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .radix     (radix),
  .strobe    (strobe),
  .character (character),
  .last      (last),
  .error     (error)
);
